// ===== rtl/core/flow_hash_node_select_top_assert.svh =====
// Assertion macros shared by the flow hash node select RTL.
`ifndef FLOW_HASH_NODE_SELECT_TOP_ASSERT_SVH
`define FLOW_HASH_NODE_SELECT_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define FHNS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked from one clock edge to the next.
`define FHNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fhns_pkg.sv =====
// Types, constants and hash helper functions for the flow hash node select block.
package fhns_pkg;

    // Hash and protocol constants.
    localparam logic [31:0] GOLDEN_RATIO  = 32'h9e37_79b9;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_DCCP    = 8'd33;
    localparam logic [7:0]  PROTO_SCTP    = 8'd132;
    localparam logic [7:0]  PROTO_UDPLITE = 8'd136;

    // Hash mode codes.
    localparam logic [1:0] MODE_ADDR       = 2'd0;
    localparam logic [1:0] MODE_ADDR_SPORT = 2'd1;
    localparam logic [1:0] MODE_ADDR_PORTS = 2'd2;

    // Connection kind codes.
    localparam logic [1:0] KIND_RELATED = 2'd1;
    localparam logic [1:0] KIND_NEW     = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_KEY_MODE    = 2'd0;
    localparam logic [1:0] REG_HASH_SEED   = 2'd1;
    localparam logic [1:0] REG_TOTAL_NODES = 2'd2;
    localparam logic [1:0] REG_LOCAL_MASK  = 2'd3;

    // Mixing schedule of the lookup2 hash: one row per pipeline stage.
    localparam int MIX_ROWS = 9;
    localparam int unsigned MIX_SHIFT [MIX_ROWS] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};

    localparam int NODE_W = 5;
    localparam int MASK_W = 16;
    localparam int PROD_W = 32 + NODE_W;

    // Packet request and decision response.
    typedef struct packed {
        logic        has_conntrack;
        logic [1:0]  conn_kind;
        logic        is_reply;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [15:0] first_port_word;
        logic [15:0] second_port_word;
    } pkt_req_t;

    typedef struct packed {
        logic              verdict;
        logic [NODE_W-1:0] node_number;
        logic              write_mark;
    } dec_rsp_t;

    // Hash state words.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    // Which word a mixing row updates.
    typedef enum logic [1:0] {
        MIX_A,
        MIX_B,
        MIX_C
    } mix_var_t;

    // How the packet is decided.
    typedef enum logic [1:0] {
        CLS_DROP,
        CLS_PASS,
        CLS_HASH
    } cls_t;

    // Decision information that travels beside the hash state.
    typedef struct packed {
        cls_t cls;
        logic zero_hash;
        logic write_mark;
    } side_t;

    // True for protocols whose first transport words are ports.
    function automatic logic proto_has_ports(input logic [7:0] p);
        return (p == PROTO_TCP) || (p == PROTO_UDP) || (p == PROTO_UDPLITE) ||
               (p == PROTO_SCTP) || (p == PROTO_DCCP) || (p == PROTO_ICMP);
    endfunction

    // One row of the lookup2 mix: two subtractions and a shifted xor.
    function automatic abc_t mix_row(input mix_var_t sel, input int unsigned sh,
                                     input abc_t v);
        abc_t r;
        r = v;
        unique case (sel)
            MIX_A:
            begin
                r.a = v.a - v.b - v.c;
                r.a = r.a ^ (v.c >> sh);
            end
            MIX_B:
            begin
                r.b = v.b - v.c - v.a;
                r.b = r.b ^ (v.a << sh);
            end
            MIX_C:
            begin
                r.c = v.c - v.a - v.b;
                r.c = r.c ^ (v.b >> sh);
            end
            default:
            begin
                r = v;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/flow_hash_node_select_top.sv =====
// Top level of the flow hash node select block: configuration registers and pipeline.
//
//   Channel   Direction  Handshake                 Payload
//   pkt       in         pkt_valid / pkt_stall     fhns_pkg::pkt_req_t
//   dec       out        dec_valid / dec_stall     fhns_pkg::dec_rsp_t
//   config    in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One request is taken every cycle unless dec is stalled; its response appears on dec after
// the request passes twelve register stages: entry stage, nine lookup2 mixing
// stages, a multiply stage, the output register.
// The mixing rows set the depth: one row of two subtractions and a shifted xor per stage.
// rst_n clears all valid bits and loads the register reset values at once.
// When the response is stalled the whole pipeline holds and pkt_stall rises.
`include "flow_hash_node_select_top_assert.svh"

module flow_hash_node_select_top #(
    parameter int MAX_NODES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pkt_valid,
    output logic               pkt_stall,
    input  fhns_pkg::pkt_req_t pkt,
    output logic               dec_valid,
    input  logic               dec_stall,
    output fhns_pkg::dec_rsp_t dec,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fhns_pkg::*;

    logic [1:0]        key_mode_reg;
    logic [31:0]       hash_seed_reg;
    logic [NODE_W-1:0] total_nodes_reg;
    logic [MASK_W-1:0] local_node_mask_reg;
    logic [MASK_W-1:0] serve_mask;
    logic              cfg_write;
    logic              en;
    logic              mix_valid;
    abc_t              mix_abc;
    side_t             mix_side;
    logic              mark_no_node;
    logic              pass_out_range;

    // Pipeline advances unless a finished response is held.
    assign en        = !dec_valid || !dec_stall;
    assign pkt_stall = !en;

    // Configuration register writes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg        <= MODE_ADDR;
            hash_seed_reg       <= '0;
            total_nodes_reg     <= NODE_W'(1);
            local_node_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_KEY_MODE:    key_mode_reg        <= pwdata[1:0];
                REG_HASH_SEED:   hash_seed_reg       <= pwdata;
                REG_TOTAL_NODES: total_nodes_reg     <= pwdata[NODE_W-1:0];
                REG_LOCAL_MASK:  local_node_mask_reg <= pwdata[MASK_W-1:0];
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_KEY_MODE:    prdata = {30'd0, key_mode_reg};
            REG_HASH_SEED:   prdata = hash_seed_reg;
            REG_TOTAL_NODES: prdata = {{(32-NODE_W){1'b0}}, total_nodes_reg};
            REG_LOCAL_MASK:  prdata = {{(32-MASK_W){1'b0}}, local_node_mask_reg};
        endcase
    end

    // Nodes above MAX_NODES are never served here.
    always_comb
    begin
        for (int k = 0; k < MASK_W; k++)
        begin
            serve_mask[k] = local_node_mask_reg[k] && (k < MAX_NODES);
        end
    end

    fhns_mix_pipe u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pkt_valid),
        .in_req    (pkt),
        .key_mode  (key_mode_reg),
        .hash_seed (hash_seed_reg),
        .out_valid (mix_valid),
        .out_abc   (mix_abc),
        .out_side  (mix_side)
    );

    fhns_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (mix_valid),
        .in_abc      (mix_abc),
        .in_side     (mix_side),
        .total_nodes (total_nodes_reg),
        .serve_mask  (serve_mask),
        .out_valid   (dec_valid),
        .out_rsp     (dec)
    );

    // Response conditions watched by the assertions below.
    assign mark_no_node   = dec.write_mark && (dec.node_number == '0);
    assign pass_out_range = dec.verdict && (dec.node_number != '0) &&
                            ((dec.node_number > NODE_W'(MASK_W)) ||
                             (32'(dec.node_number) > MAX_NODES));

    // A response without a node never asks for a mark write.
    `FHNS_ASSERT_ALWAYS(a_no_node_no_mark, !(dec_valid && mark_no_node), "mark without node")
    // A passed hashed packet names a node this block can serve.
    `FHNS_ASSERT_ALWAYS(a_pass_node_range, !(dec_valid && pass_out_range), "node out of range")
    // Requests are held back only while a response waits.
    `FHNS_ASSERT_ALWAYS(a_stall_cause, !pkt_stall || (dec_valid && dec_stall), "stray stall")
    // A held response is still there in the next cycle.
    `FHNS_ASSERT_NEXT(a_held_rsp, dec_valid && dec_stall, dec_valid, "held response lost")

endmodule

// ===== rtl/core/fhns_mix_pipe.sv =====
// Request classification, hash setup and the nine-stage lookup2 mixing pipeline.
module fhns_mix_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fhns_pkg::pkt_req_t in_req,
    input  logic [1:0]        key_mode,
    input  logic [31:0]       hash_seed,
    output logic              out_valid,
    output fhns_pkg::abc_t    out_abc,
    output fhns_pkg::side_t   out_side
);
    import fhns_pkg::*;

    logic   valid_reg [MIX_ROWS+1];
    abc_t   abc_reg   [MIX_ROWS+1];
    side_t  side_reg  [MIX_ROWS+1];

    logic   ports_ok;
    logic [31:0] sport;
    logic [31:0] dport;
    abc_t   init_abc;
    side_t  init_side;

    // Classify the request and load the initial hash words.
    always_comb
    begin
        ports_ok = proto_has_ports(in_req.ip_protocol);
        sport = ports_ok ? {16'd0, in_req.first_port_word}  : 32'd0;
        dport = ports_ok ? {16'd0, in_req.second_port_word} : 32'd0;

        init_abc.a = in_req.source_address + GOLDEN_RATIO;
        init_abc.b = GOLDEN_RATIO;
        init_abc.c = hash_seed;
        init_side.zero_hash = 1'b0;
        unique case (key_mode)
            MODE_ADDR:
            begin
                init_abc.b = GOLDEN_RATIO;
            end
            MODE_ADDR_SPORT:
            begin
                init_abc.b = sport + GOLDEN_RATIO;
            end
            MODE_ADDR_PORTS:
            begin
                init_abc.b = sport + GOLDEN_RATIO;
                init_abc.c = dport + hash_seed;
            end
            default:
            begin
                init_side.zero_hash = 1'b1;
            end
        endcase

        init_side.write_mark = 1'b0;
        priority if (!in_req.has_conntrack)
        begin
            init_side.cls = CLS_DROP;
        end
        else if (in_req.ip_protocol == PROTO_ICMP && in_req.conn_kind == KIND_RELATED)
        begin
            init_side.cls = CLS_PASS;
        end
        else
        begin
            init_side.cls = CLS_HASH;
            init_side.write_mark = (in_req.conn_kind == KIND_NEW) && !in_req.is_reply;
        end
    end

    // Entry stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abc_reg[0]  <= init_abc;
            side_reg[0] <= init_side;
        end
    end

    // One mixing row per stage.
    for (genvar r = 0; r < MIX_ROWS; r++)
    begin : g_row
        localparam int ROW_SEL = r % 3;
        localparam mix_var_t ROW_VAR = mix_var_t'(ROW_SEL);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[r+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[r+1] <= valid_reg[r];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                abc_reg[r+1]  <= mix_row(ROW_VAR, MIX_SHIFT[r], abc_reg[r]);
                side_reg[r+1] <= side_reg[r];
            end
        end
    end

    assign out_valid = valid_reg[MIX_ROWS];
    assign out_abc   = abc_reg[MIX_ROWS];
    assign out_side  = side_reg[MIX_ROWS];

endmodule

// ===== rtl/core/fhns_scale.sv =====
// Scales the hash to a node number and forms the final decision in the output register.
module fhns_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  fhns_pkg::abc_t                in_abc,
    input  fhns_pkg::side_t               in_side,
    input  logic [fhns_pkg::NODE_W-1:0]   total_nodes,
    input  logic [fhns_pkg::MASK_W-1:0]   serve_mask,
    output logic                          out_valid,
    output fhns_pkg::dec_rsp_t            out_rsp
);
    import fhns_pkg::*;

    logic              prod_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    side_t             prod_side_reg;
    logic              out_valid_reg;
    dec_rsp_t          out_reg;
    dec_rsp_t          out_next;
    logic [31:0]       hash;
    logic [NODE_W-1:0] node_idx;
    logic              served;

    // Multiply stage: hash times node count.
    always_comb
    begin
        hash = in_side.zero_hash ? 32'd0 : in_abc.c;
        prod_next = PROD_W'(hash) * PROD_W'(total_nodes);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg      <= prod_next;
            prod_side_reg <= in_side;
        end
    end

    // Node selection and verdict.
    always_comb
    begin
        node_idx = prod_reg[PROD_W-1:32];
        served = (node_idx < NODE_W'(MASK_W)) && serve_mask[node_idx[3:0]];
        unique case (prod_side_reg.cls)
            CLS_DROP:
            begin
                out_next = '{verdict: 1'b0, node_number: '0, write_mark: 1'b0};
            end
            CLS_PASS:
            begin
                out_next = '{verdict: 1'b1, node_number: '0, write_mark: 1'b0};
            end
            default:
            begin
                out_next.verdict     = served;
                out_next.node_number = node_idx + NODE_W'(1);
                out_next.write_mark  = prod_side_reg.write_mark;
            end
        endcase
    end

    // Output register; holds while the response is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the flow hash node select block: directed and random packets checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fhns_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] KIND_ESTABLISHED = 2'd0;
    localparam logic [1:0] KIND_RESERVED    = 2'd3;
    localparam logic [1:0] MODE_ZERO_HASH   = 2'd3;
    localparam logic [7:0] PROTO_HOPOPT     = 8'd0;
    localparam logic [7:0] PROTO_GRE        = 8'd47;
    localparam logic [7:0] PROTO_RAW        = 8'd255;

    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_GUARD   = 50000;

    // Clock, reset and block ports.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        pkt_valid = 1'b0;
    logic        pkt_stall;
    pkt_req_t    pkt       = '0;
    logic        dec_valid;
    logic        dec_stall = 1'b0;
    dec_rsp_t    dec;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the configuration registers.
    logic [1:0]  cfg_mode  = MODE_ADDR;
    logic [31:0] cfg_seed  = '0;
    logic [4:0]  cfg_nodes = 5'd1;
    logic [15:0] cfg_mask  = '0;

    // Decisions predicted for accepted packets, oldest first.
    dec_rsp_t pending_dec[$];
    int       err_count = 0;

    // Idle rates and the long receiver hold-off request.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_len      = 0;
    int          hold_ticket   = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;

    flow_hash_node_select_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec       (dec),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    // Lookup2 hash over three words with the golden ratio and a seed.
    function automatic logic [31:0] jenkins_hash3(input logic [31:0] w0, input logic [31:0] w1,
                                                  input logic [31:0] w2, input logic [31:0] seed);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = w0 + GOLDEN_RATIO;
        b = w1 + GOLDEN_RATIO;
        c = w2 + seed;
        a = a - b - c;  a = a ^ (c >> 13);
        b = b - c - a;  b = b ^ (a << 8);
        c = c - a - b;  c = c ^ (b >> 13);
        a = a - b - c;  a = a ^ (c >> 12);
        b = b - c - a;  b = b ^ (a << 16);
        c = c - a - b;  c = c ^ (b >> 5);
        a = a - b - c;  a = a ^ (c >> 3);
        b = b - c - a;  b = b ^ (a << 10);
        c = c - a - b;  c = c ^ (b >> 15);
        return c;
    endfunction

    // Decision expected for one packet under the current register settings.
    function automatic dec_rsp_t predict_decision(input pkt_req_t p);
        dec_rsp_t    d;
        logic [31:0] sport;
        logic [31:0] dport;
        logic [31:0] h;
        logic [36:0] prod;
        logic [5:0]  node;
        logic [5:0]  bit_idx;
        logic        carries_ports;
        d = '0;
        if (!p.has_conntrack)
            return d;
        if (p.ip_protocol == PROTO_ICMP && p.conn_kind == KIND_RELATED)
        begin
            d.verdict = 1'b1;
            return d;
        end
        case (p.ip_protocol)
            PROTO_TCP, PROTO_UDP, PROTO_UDPLITE, PROTO_SCTP, PROTO_DCCP, PROTO_ICMP:
                carries_ports = 1'b1;
            default:
                carries_ports = 1'b0;
        endcase
        sport = carries_ports ? {16'd0, p.first_port_word} : 32'd0;
        dport = carries_ports ? {16'd0, p.second_port_word} : 32'd0;
        case (cfg_mode)
            MODE_ADDR:       h = jenkins_hash3(p.source_address, 32'd0, 32'd0, cfg_seed);
            MODE_ADDR_SPORT: h = jenkins_hash3(p.source_address, sport, 32'd0, cfg_seed);
            MODE_ADDR_PORTS: h = jenkins_hash3(p.source_address, sport, dport, cfg_seed);
            default:         h = 32'd0;
        endcase
        prod    = {5'd0, h} * {32'd0, cfg_nodes};
        node    = {1'b0, prod[36:32]} + 6'd1;
        bit_idx = node - 6'd1;
        d.verdict     = (bit_idx < 6'd16) && cfg_mask[bit_idx[3:0]];
        d.node_number = node[4:0];
        d.write_mark  = (p.conn_kind == KIND_NEW) && !p.is_reply;
        return d;
    endfunction

    function automatic pkt_req_t make_pkt(input logic ct, input logic [1:0] kind,
                                          input logic reply, input logic [7:0] proto,
                                          input logic [31:0] addr, input logic [15:0] w1,
                                          input logic [15:0] w2);
        pkt_req_t p;
        p.has_conntrack    = ct;
        p.conn_kind        = kind;
        p.is_reply         = reply;
        p.ip_protocol      = proto;
        p.source_address   = addr;
        p.first_port_word  = w1;
        p.second_port_word = w2;
        return p;
    endfunction

    // Mostly tracked, port-carrying packets; some untracked and odd protocols.
    function automatic pkt_req_t random_pkt();
        pkt_req_t p;
        int unsigned pick;
        p = make_pkt($urandom_range(99) < 90, 2'($urandom), 1'($urandom), 8'($urandom),
                     $urandom, 16'($urandom), 16'($urandom));
        pick = $urandom_range(9);
        case (pick)
            0:       p.ip_protocol = PROTO_ICMP;
            1, 2:    p.ip_protocol = PROTO_TCP;
            3:       p.ip_protocol = PROTO_UDP;
            4:       p.ip_protocol = PROTO_UDPLITE;
            5:       p.ip_protocol = PROTO_SCTP;
            6:       p.ip_protocol = PROTO_DCCP;
            default: ;
        endcase
        if ($urandom_range(19) == 0)
            p.source_address = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
        return p;
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Register write: setup cycle, access cycle, then idle.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_MODE:    cfg_mode  = val[1:0];
            REG_HASH_SEED:   cfg_seed  = val;
            REG_TOTAL_NODES: cfg_nodes = val[4:0];
            REG_LOCAL_MASK:  cfg_mask  = val[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [1:0] mode, input logic [31:0] seed,
                                  input logic [4:0] nodes, input logic [15:0] mask);
        reg_write(REG_KEY_MODE, ($urandom & 32'hffff_fffc) | {30'd0, mode});
        reg_write(REG_HASH_SEED, seed);
        reg_write(REG_TOTAL_NODES, ($urandom & 32'hffff_ffe0) | {27'd0, nodes});
        reg_write(REG_LOCAL_MASK, ($urandom & 32'hffff_0000) | {16'd0, mask});
    endtask

    // Offer one request, possibly after random idle cycles, and hold it until taken.
    task automatic send_pkt(input pkt_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt_valid <= 1'b0;
            @(posedge clk);
        end
        pkt_valid <= 1'b1;
        pkt       <= r;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
        pending_dec.push_back(predict_decision(r));
    endtask

    // Stop offering and wait until every predicted decision has come back.
    task automatic drain_decisions();
        int guard;
        guard = 0;
        pkt_valid <= 1'b0;
        while (pending_dec.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_dec.size() != 0)
        begin
            flag_mismatch($sformatf("%0d decisions never arrived", pending_dec.size()));
            pending_dec.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver stall: a requested long hold-off first, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_ticket != hold_seen)
        begin
            hold_seen <= hold_ticket;
            hold_left <= hold_len;
            dec_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            dec_stall <= 1'b1;
        end
        else
        begin
            dec_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted decision with the oldest prediction.
    always @(posedge clk)
    begin
        dec_rsp_t want;
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (pending_dec.size() == 0)
            begin
                flag_mismatch("decision with no packet outstanding");
            end
            else
            begin
                want = pending_dec.pop_front();
                if (dec.verdict !== want.verdict)
                    flag_mismatch($sformatf("verdict %b, predicted %b",
                                            dec.verdict, want.verdict));
                if (dec.node_number !== want.node_number)
                    flag_mismatch($sformatf("node_number %0d, predicted %0d",
                                            dec.node_number, want.node_number));
                if (dec.write_mark !== want.write_mark)
                    flag_mismatch($sformatf("write_mark %b, predicted %b",
                                            dec.write_mark, want.write_mark));
            end
        end
    end

    // Reset values: every hashed packet lands on node 1 and is dropped.
    task automatic test_reset_values();
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_TCP, 32'h0a00_0001, 16'd80, 16'd443));
        send_pkt(make_pkt(1'b1, KIND_ESTABLISHED, 1'b1, PROTO_UDP, $urandom, 16'd53, 16'd53));
        send_pkt(make_pkt(1'b0, KIND_NEW, 1'b0, PROTO_TCP, $urandom, 16'd1, 16'd2));
        send_pkt(make_pkt(1'b1, KIND_RELATED, 1'b0, PROTO_ICMP, $urandom, 16'd0, 16'd0));
        drain_decisions();
    endtask

    // Field extremes, every protocol class and each special case by hand.
    task automatic test_directed_cases();
        write_all_regs(MODE_ADDR_PORTS, 32'hdead_beef, 5'd16, 16'haaaa);
        // No tracked connection, with every other field at both extremes.
        send_pkt(make_pkt(1'b0, KIND_RESERVED, 1'b1, PROTO_RAW, 32'hffff_ffff,
                          16'hffff, 16'hffff));
        send_pkt(make_pkt(1'b0, KIND_ESTABLISHED, 1'b0, PROTO_HOPOPT, 32'h0, 16'h0, 16'h0));
        // ICMP of a related connection passes in both directions.
        send_pkt(make_pkt(1'b1, KIND_RELATED, 1'b0, PROTO_ICMP, 32'hc0a8_0101, 16'h0800, 16'h1));
        send_pkt(make_pkt(1'b1, KIND_RELATED, 1'b1, PROTO_ICMP, 32'hffff_ffff,
                          16'hffff, 16'hffff));
        // ICMP that is not related is hashed like any port protocol.
        send_pkt(make_pkt(1'b1, KIND_ESTABLISHED, 1'b0, PROTO_ICMP, 32'h0102_0304,
                          16'h0800, 16'h4));
        // Each port-carrying protocol on a new connection.
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_TCP, 32'h0a00_0001, 16'd1234, 16'd80));
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_UDP, 32'h0a00_0002, 16'd5353, 16'd53));
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_UDPLITE, 32'h0a00_0003,
                          16'd7, 16'd9));
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_SCTP, 32'h0a00_0004, 16'd38412,
                          16'd2905));
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_DCCP, 32'h0a00_0005, 16'd5004,
                          16'd5005));
        // A new connection seen in the reply direction writes no mark.
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b1, PROTO_TCP, 32'h0a00_0001, 16'd1234, 16'd80));
        // Protocols without ports hash as if both words were zero.
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_GRE, 32'h0a00_0006, 16'hffff, 16'hffff));
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_GRE, 32'h0a00_0006, 16'h0, 16'h0));
        send_pkt(make_pkt(1'b1, KIND_ESTABLISHED, 1'b0, PROTO_RAW, 32'h0, 16'h1234, 16'h5678));
        send_pkt(make_pkt(1'b1, KIND_ESTABLISHED, 1'b1, PROTO_HOPOPT, 32'hffff_ffff,
                          16'hffff, 16'h0));
        // The reserved connection kind behaves as established.
        send_pkt(make_pkt(1'b1, KIND_RESERVED, 1'b0, PROTO_TCP, 32'h0a00_0001, 16'd1234,
                          16'd80));
        send_pkt(make_pkt(1'b1, KIND_RESERVED, 1'b0, PROTO_ICMP, 32'h0a00_0007, 16'h0, 16'h0));
        // A related connection of a port protocol is hashed.
        send_pkt(make_pkt(1'b1, KIND_RELATED, 1'b0, PROTO_TCP, 32'h0a00_0008, 16'd20, 16'd21));
        // Address and port extremes.
        send_pkt(make_pkt(1'b1, KIND_ESTABLISHED, 1'b0, PROTO_UDP, 32'h0, 16'h0, 16'h0));
        send_pkt(make_pkt(1'b1, KIND_ESTABLISHED, 1'b0, PROTO_UDP, 32'hffff_ffff,
                          16'hffff, 16'hffff));
        drain_decisions();
        // A new connection that this host does not serve still asks for a mark.
        reg_write(REG_LOCAL_MASK, 32'h0);
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_TCP, 32'h0a00_0009, 16'd1, 16'd2));
        send_pkt(make_pkt(1'b1, KIND_NEW, 1'b0, PROTO_UDP, 32'hffff_ffff, 16'hffff, 16'hffff));
        drain_decisions();
    endtask

    // Register corners: zero hash mode, zero nodes, nodes past the mask width.
    task automatic test_config_corners();
        logic [1:0]  modes [5] = '{MODE_ZERO_HASH, MODE_ADDR, MODE_ADDR_SPORT,
                                   MODE_ADDR_PORTS, MODE_ADDR_PORTS};
        logic [31:0] seeds [5] = '{32'h0, 32'hffff_ffff, 32'h1234_5678, 32'h0, 32'hffff_ffff};
        logic [4:0]  nodes [5] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17};
        logic [15:0] masks [5] = '{16'hffff, 16'hffff, 16'h0001, 16'hffff, 16'h0};
        for (int s = 0; s < 5; s++)
        begin
            write_all_regs(modes[s], seeds[s], nodes[s], masks[s]);
            repeat (8) send_pkt(random_pkt());
            drain_decisions();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering, so the pipeline fills.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all_regs(MODE_ADDR_PORTS, $urandom, 5'd12, 16'($urandom));
        hold_len = 300;
        hold_ticket++;
        repeat (80) send_pkt(random_pkt());
        drain_decisions();
    endtask

    // Random packets in blocks, with fresh register settings between blocks.
    task automatic test_random_traffic(input int unsigned sidle, input int unsigned ridle,
                                       input int n_items);
        int         sent;
        int         block;
        logic [1:0] mode;
        logic [4:0] n;
        logic [15:0] mask;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        sent = 0;
        while (sent < n_items)
        begin
            mode = ($urandom_range(9) == 0) ? MODE_ZERO_HASH : 2'($urandom_range(2));
            n    = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(16, 1));
            mask = ($urandom_range(5) == 0) ? 16'hffff : 16'($urandom);
            write_all_regs(mode, $urandom, n, mask);
            block = $urandom_range(160, 80);
            for (int i = 0; i < block && sent < n_items; i++)
            begin
                send_pkt(random_pkt());
                sent++;
            end
            drain_decisions();
        end
    endtask

    // Test sequence and final verdict.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_cases();
        test_config_corners();
        test_backpressure();
        test_random_traffic(10, 67, 570);
        test_random_traffic(67, 10, 570);
        test_random_traffic(0, 0, 570);
        drain_decisions();
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
